### rtl/one_wire_bus_master_macros.svh
// Assertion macros shared by the one-wire bus master RTL.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OWBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OWBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/owbm_pkg.sv
// Package with payload types, codes and register defaults of the one-wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int unsigned CFG_WIDTH     = 10;
    localparam int unsigned NUM_CFG       = 8;
    localparam int unsigned CFG_IDX_WIDTH = 4;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_RESET_LOW      = 4'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PRESENCE_SMP   = 4'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RESET_REC      = 4'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SLOT_START     = 4'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WRITE_SLOT     = 4'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SLOT_REC       = 4'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_READ_SAMPLE    = 4'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_READ_TAIL      = 4'd7;

    localparam logic [CFG_WIDTH-1:0] CFG_RESET [NUM_CFG] = '{
        10'd600, 10'd60, 10'd40, 10'd2, 10'd60, 10'd10, 10'd16, 10'd60
    };

    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    localparam logic [1:0] CMD_RESET = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [1:0] command;
        logic [7:0] write_byte;
        logic       bus_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
    } t_out_item;

endpackage

### rtl/one_wire_bus_master.sv
// The result of an accepted item is registered straight into the output register.
// Throughput: one item per cycle; a single stage updates the bus state and the result.
// The output register frees its slot in the same cycle it is taken, so input stalls
// only while a result waits unread. Reset (synchronous, active low) returns the
// sequencer to idle, clears presence and the read byte and reloads the timing registers.
`timescale 1ns / 1ps
`include "one_wire_bus_master_macros.svh"

module one_wire_bus_master
    import owbm_pkg::*;
#(
    parameter int unsigned TICK_WIDTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_item,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data
);

    localparam int unsigned LIM_WIDTH = (TICK_WIDTH > CFG_WIDTH) ? TICK_WIDTH : CFG_WIDTH;
    localparam logic [TICK_WIDTH-1:0] TMAX = {TICK_WIDTH{1'b1}};

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_HOLD,
        PH_RST_REC,
        PH_W_START,
        PH_W_DATA,
        PH_W_REC,
        PH_R_START,
        PH_R_WAIT,
        PH_R_TAIL
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [TICK_WIDTH-1:0]   r_tick, n_tick;
    logic [2:0]              r_bit, n_bit;
    logic [7:0]              r_shift, n_shift;
    logic                    r_presence, n_presence;
    logic [7:0]              r_read_hold, n_read_hold;
    logic [CFG_WIDTH-1:0]    r_cfg [NUM_CFG];
    logic                    r_out_valid;
    t_out_item               r_out, n_out;

    logic                    in_fire;
    logic [TICK_WIDTH-1:0]   tick_inc;
    logic [CFG_WIDTH-1:0]    lim_sel;
    logic [LIM_WIDTH-1:0]    lim_ext;
    logic [LIM_WIDTH-1:0]    lim_clamped;
    logic                    lim_hit;
    logic                    done;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign in_fire     = i_in_valid && o_in_ready;

    assign tick_inc = (r_tick != TMAX) ? r_tick + 1'b1 : r_tick;

    always_comb begin
        case (r_phase)
            PH_RST_LOW:  lim_sel = r_cfg[REG_RESET_LOW[2:0]];
            PH_RST_WAIT: lim_sel = r_cfg[REG_PRESENCE_SMP[2:0]];
            PH_RST_REC:  lim_sel = r_cfg[REG_RESET_REC[2:0]];
            PH_W_START:  lim_sel = r_cfg[REG_SLOT_START[2:0]];
            PH_R_START:  lim_sel = r_cfg[REG_SLOT_START[2:0]];
            PH_W_DATA:   lim_sel = r_cfg[REG_WRITE_SLOT[2:0]];
            PH_W_REC:    lim_sel = r_cfg[REG_SLOT_REC[2:0]];
            PH_R_WAIT:   lim_sel = r_cfg[REG_READ_SAMPLE[2:0]];
            PH_R_TAIL:   lim_sel = r_cfg[REG_READ_TAIL[2:0]];
            default:     lim_sel = '0;
        endcase
        lim_ext     = LIM_WIDTH'(lim_sel);
        lim_clamped = (lim_ext > LIM_WIDTH'(TMAX)) ? LIM_WIDTH'(TMAX) : lim_ext;
        lim_hit     = LIM_WIDTH'(tick_inc) >= lim_clamped;
    end

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_presence  = r_presence;
        n_read_hold = r_read_hold;
        done        = 1'b0;

        if (i_in_item.req_type == REQ_COMMAND) begin
            if (r_phase == PH_IDLE) begin
                case (i_in_item.command)
                    CMD_RESET: begin
                        n_bit   = '0;
                        n_phase = PH_RST_LOW;
                        n_tick  = '0;
                    end
                    CMD_WRITE: begin
                        n_bit   = '0;
                        n_shift = i_in_item.write_byte;
                        n_phase = PH_W_START;
                        n_tick  = '0;
                    end
                    CMD_READ: begin
                        n_bit   = '0;
                        n_shift = '0;
                        n_phase = PH_R_START;
                        n_tick  = '0;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end else if (r_phase != PH_IDLE) begin
            n_tick = tick_inc;
            case (r_phase)
                PH_RST_LOW: begin
                    if (lim_hit) begin
                        n_phase = PH_RST_WAIT;
                        n_tick  = '0;
                    end
                end
                PH_RST_WAIT: begin
                    if (lim_hit) begin
                        n_presence = !i_in_item.bus_level;
                        n_phase    = i_in_item.bus_level ? PH_RST_REC : PH_RST_HOLD;
                        n_tick     = '0;
                    end
                end
                PH_RST_HOLD: begin
                    if (i_in_item.bus_level) begin
                        n_phase = PH_RST_REC;
                        n_tick  = '0;
                    end
                end
                PH_RST_REC: begin
                    if (lim_hit) begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                        done    = 1'b1;
                    end
                end
                PH_W_START: begin
                    if (lim_hit) begin
                        n_phase = PH_W_DATA;
                        n_tick  = '0;
                    end
                end
                PH_W_DATA: begin
                    if (lim_hit) begin
                        n_phase = PH_W_REC;
                        n_tick  = '0;
                    end
                end
                PH_W_REC: begin
                    if (lim_hit) begin
                        n_tick = '0;
                        if (r_bit == 3'd7) begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_phase = PH_W_START;
                        end
                    end
                end
                PH_R_START: begin
                    // The count keeps running from the start of the slot.
                    if (lim_hit) begin
                        n_phase = PH_R_WAIT;
                    end
                end
                PH_R_WAIT: begin
                    if (lim_hit) begin
                        n_shift = {i_in_item.bus_level, r_shift[7:1]};
                        n_phase = PH_R_TAIL;
                        n_tick  = '0;
                    end
                end
                PH_R_TAIL: begin
                    if (lim_hit) begin
                        n_tick = '0;
                        if (r_bit == 3'd7) begin
                            n_read_hold = r_shift;
                            n_phase     = PH_IDLE;
                            done        = 1'b1;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_phase = PH_R_START;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            endcase
        end

        n_out.busy_res  = n_phase != PH_IDLE;
        n_out.done_res  = done;
        n_out.presence  = n_presence;
        n_out.read_byte = n_read_hold;
        case (n_phase)
            PH_RST_LOW, PH_W_START, PH_R_START: n_out.drive_low = 1'b1;
            PH_W_DATA:                          n_out.drive_low = !n_shift[n_bit];
            default:                            n_out.drive_low = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_presence  <= 1'b0;
            r_read_hold <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CFG; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else begin
            if (i_cfg_valid && i_cfg_index < CFG_IDX_WIDTH'(NUM_CFG)) begin
                r_cfg[i_cfg_index[2:0]] <= i_cfg_data;
            end
            if (in_fire) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_presence  <= n_presence;
                r_read_hold <= n_read_hold;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    `OWBM_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_out.done_res, !r_out.busy_res, "done result while still busy")
    `OWBM_ASSERT_NOW(a_drive_needs_busy, i_clk, i_rst_n, r_out_valid && r_out.drive_low, r_out.busy_res, "bus driven low while idle")
    `OWBM_ASSERT_NEXT(a_cmd_starts, i_clk, i_rst_n, in_fire && i_in_item.req_type == REQ_COMMAND && r_phase == PH_IDLE && (i_in_item.command == CMD_RESET || i_in_item.command == CMD_WRITE || i_in_item.command == CMD_READ), r_phase != PH_IDLE && o_out_valid && o_out_item.busy_res, "valid command did not start an operation")
    `OWBM_ASSERT_NEXT(a_idle_tick_holds, i_clk, i_rst_n, in_fire && i_in_item.req_type == REQ_TICK && r_phase == PH_IDLE, r_phase == PH_IDLE && !o_out_item.done_res, "tick changed an idle sequencer")

endmodule
